FILE: hdl/plom_pkg.sv
// Shared types and constants for the price level order matcher.
// Used by plom_cell, plom_book and price_level_order_matcher; depends on nothing.
`timescale 1ns / 1ps

package plom_pkg;

    localparam int PRICE_W   = 32;
    localparam int QTY_W     = 32;
    localparam int ORD_QTY_W = 16;

    // Result action codes.
    typedef enum logic [1:0] {
        ACT_NEW    = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_CROSS  = 2'd2,
        ACT_REJECT = 2'd3
    } action_t;

    // Operation applied to one book in the update cycle.
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_POP    = 2'd1,
        OP_ADD    = 2'd2,
        OP_INSERT = 2'd3
    } book_op_t;

    // Command from the controller to every cell of one book.
    typedef struct packed {
        logic     capture;
        book_op_t op;
    } book_cmd_t;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic               valid;
        logic               ahead;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } cell_bus_t;

    // Summary of one book for the controller.
    typedef struct packed {
        logic               head_valid;
        logic [PRICE_W-1:0] head_price;
        logic [QTY_W-1:0]   head_qty;
        logic               head_reach;
        logic               any_match;
        logic               full;
        logic [QTY_W-1:0]   add_qty;
        logic               add_sat;
        logic               best_next_valid;
        logic [PRICE_W-1:0] best_next_price;
    } book_stat_t;

endpackage

FILE: hdl/plom_cell.sv
// One price level of a book: price, aggregate quantity, valid bit and the
// compare flags taken when an order arrives. Depends on plom_pkg.
`timescale 1ns / 1ps

module plom_cell #(
    parameter bit DESCENDING = 1'b0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  plom_pkg::book_cmd_t           cmd,
    input  logic [plom_pkg::PRICE_W-1:0]  cmp_price,
    input  logic [plom_pkg::PRICE_W-1:0]  ord_price,
    input  logic [plom_pkg::ORD_QTY_W-1:0] ord_qty,
    input  plom_pkg::cell_bus_t           left,
    input  plom_pkg::cell_bus_t           right,
    output plom_pkg::cell_bus_t           self_bus,
    output logic                          match,
    output logic                          reach,
    output logic [plom_pkg::QTY_W-1:0]    sum_qty,
    output logic                          sum_sat
);

    logic                         valid_reg, valid_next;
    logic [plom_pkg::PRICE_W-1:0] price_reg, price_next;
    logic [plom_pkg::QTY_W-1:0]   qty_reg, qty_next;
    logic                         eq_reg, gt_reg, lt_reg;
    logic [plom_pkg::QTY_W:0]     sum_wide;
    logic                         ahead;

    assign ahead = valid_reg & (DESCENDING ? gt_reg : lt_reg);
    assign match = valid_reg & eq_reg;
    assign reach = valid_reg & (DESCENDING ? (gt_reg | eq_reg) : (lt_reg | eq_reg));

    assign self_bus = '{valid: valid_reg, ahead: ahead, price: price_reg, qty: qty_reg};

    // Saturating add of the order quantity onto this level.
    assign sum_wide = {1'b0, qty_reg}
                    + {{(plom_pkg::QTY_W + 1 - plom_pkg::ORD_QTY_W){1'b0}}, ord_qty};
    assign sum_sat  = sum_wide[plom_pkg::QTY_W];
    assign sum_qty  = sum_sat ? {plom_pkg::QTY_W{1'b1}} : sum_wide[plom_pkg::QTY_W-1:0];

    always_comb begin
        valid_next = valid_reg;
        price_next = price_reg;
        qty_next   = qty_reg;
        case (cmd.op)
            plom_pkg::OP_POP: begin
                valid_next = right.valid;
                price_next = right.price;
                qty_next   = right.qty;
            end
            plom_pkg::OP_ADD: begin
                if (match) begin
                    qty_next = sum_qty;
                end
            end
            plom_pkg::OP_INSERT: begin
                // Levels ahead of the new price stay; the first one behind it
                // takes the new level and the rest move one place down.
                if (!ahead) begin
                    if (left.ahead) begin
                        valid_next = 1'b1;
                        price_next = ord_price;
                        qty_next   = {{(plom_pkg::QTY_W - plom_pkg::ORD_QTY_W){1'b0}}, ord_qty};
                    end else begin
                        valid_next = left.valid;
                        price_next = left.price;
                        qty_next   = left.qty;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
        if (cmd.capture) begin
            eq_reg <= (price_reg == cmp_price);
            gt_reg <= (price_reg >  cmp_price);
            lt_reg <= (price_reg <  cmp_price);
        end
    end

endmodule

FILE: hdl/plom_book.sv
// One side of the order book as a chain of plom_cell levels, best level in
// cell 0, plus the summary the controller needs. Depends on plom_pkg, plom_cell.
`timescale 1ns / 1ps

module plom_book #(
    parameter int LEVELS     = 16,
    parameter bit DESCENDING = 1'b0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  plom_pkg::book_cmd_t            cmd,
    input  logic [plom_pkg::PRICE_W-1:0]   cmp_price,
    input  logic [plom_pkg::PRICE_W-1:0]   ord_price,
    input  logic [plom_pkg::ORD_QTY_W-1:0] ord_qty,
    output plom_pkg::book_stat_t           stat
);

    plom_pkg::cell_bus_t          bus [0:LEVELS];
    plom_pkg::cell_bus_t          left_edge;
    logic [LEVELS-1:0]            match_vec;
    logic [LEVELS-1:0]            reach_vec;
    logic [LEVELS-1:0]            sat_vec;
    logic [plom_pkg::QTY_W-1:0]   sum_vec [0:LEVELS-1];
    logic [plom_pkg::QTY_W-1:0]   add_qty;

    // Everything is behind the virtual level in front of cell 0.
    assign left_edge   = '{valid: 1'b1, ahead: 1'b1, price: '0, qty: '0};
    assign bus[LEVELS] = '0;

    for (genvar i = 0; i < LEVELS; i++) begin : g_cell
        plom_cell #(
            .DESCENDING(DESCENDING)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .cmp_price(cmp_price),
            .ord_price(ord_price),
            .ord_qty  (ord_qty),
            .left     ((i == 0) ? left_edge : bus[(i == 0) ? 0 : i - 1]),
            .right    (bus[i + 1]),
            .self_bus (bus[i]),
            .match    (match_vec[i]),
            .reach    (reach_vec[i]),
            .sum_qty  (sum_vec[i]),
            .sum_sat  (sat_vec[i])
        );
    end

    // At most one level matches, so the sum of the matching cell is picked by OR.
    always_comb begin
        add_qty = '0;
        for (int i = 0; i < LEVELS; i++) begin
            add_qty = add_qty | (match_vec[i] ? sum_vec[i] : '0);
        end
    end

    always_comb begin
        stat.head_valid      = bus[0].valid;
        stat.head_price      = bus[0].price;
        stat.head_qty        = bus[0].qty;
        stat.head_reach      = reach_vec[0];
        stat.any_match       = |match_vec;
        stat.full            = bus[LEVELS-1].valid;
        stat.add_qty         = add_qty;
        stat.add_sat         = |(sat_vec & match_vec);
        stat.best_next_valid = bus[0].valid;
        stat.best_next_price = bus[0].price;
        case (cmd.op)
            plom_pkg::OP_POP: begin
                stat.best_next_valid = bus[1].valid;
                stat.best_next_price = bus[1].price;
            end
            plom_pkg::OP_INSERT: begin
                stat.best_next_valid = 1'b1;
                stat.best_next_price = bus[0].ahead ? bus[0].price : ord_price;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hdl/price_level_order_matcher.sv
// Price level order matcher: bid and ask books held as chains of level cells.
// A result is written into the output register in the UPD state that follows the
// accepted order transaction. A new order is taken only once the compare and update
// phases of the cell chains are done; a stalled result holds the update phase.
// Reset (aresetn low, synchronous) empties both books and drops any pending
// result; no clearing pass is needed. Depends on plom_pkg, plom_book, plom_cell.
`timescale 1ns / 1ps

module price_level_order_matcher #(
    parameter int LEVELS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // order_price [31:0], order_quantity [47:32]
    input  logic         s_axis_tuser,  // order_side [0]

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,  // level_price [31:0], level_quantity [63:32],
                                        // saturated [64], best_bid_valid [65],
                                        // best_bid_price [97:66], best_ask_valid [98],
                                        // best_ask_price [130:99], zeros above
    output logic [1:0]   m_axis_tuser   // action [1:0]
);

    // The controller has two phases. In CMP the block waits for an order; when
    // the order transaction is accepted, every cell of both books compares its
    // price against the incoming price and keeps the outcome. In UPD the
    // registered flags decide what happens: a cross pops the opposite book's
    // best level, a matching level adds the quantity, otherwise a new level is
    // inserted by shifting the chain, unless the book is full. The result is
    // written into the output register in the same cycle, so UPD waits only
    // while an older result still sits there untaken.
    typedef enum logic [1:0] {
        ST_CMP = 2'b01,
        ST_UPD = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic                              ord_side_reg;
    logic [plom_pkg::PRICE_W-1:0]      ord_price_reg;
    logic [plom_pkg::ORD_QTY_W-1:0]    ord_qty_reg;

    logic                              s_accept;
    logic                              upd_fire;

    plom_pkg::book_cmd_t               bid_cmd, ask_cmd;
    plom_pkg::book_stat_t              bid_stat, ask_stat;
    plom_pkg::book_stat_t              own_stat, opp_stat;
    plom_pkg::book_op_t                own_op, opp_op;

    plom_pkg::action_t                 act;
    logic [plom_pkg::PRICE_W-1:0]      lvl_price;
    logic [plom_pkg::QTY_W-1:0]        lvl_qty;
    logic                              lvl_sat;

    logic                              m_valid_reg, m_valid_next;
    plom_pkg::action_t                 m_action_reg;
    logic [130:0]                      m_data_reg;
    logic [130:0]                      m_data_next;

    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (state_reg == ST_CMP);
    assign upd_fire      = (state_reg == ST_UPD) & (~m_valid_reg | m_axis_tready);

    // Own book is the bid side for a buy; the opposite book is the one it may cross.
    assign own_stat = ord_side_reg ? ask_stat : bid_stat;
    assign opp_stat = ord_side_reg ? bid_stat : ask_stat;

    always_comb begin
        own_op    = plom_pkg::OP_NONE;
        opp_op    = plom_pkg::OP_NONE;
        act       = plom_pkg::ACT_NEW;
        lvl_price = ord_price_reg;
        lvl_qty   = {{(plom_pkg::QTY_W - plom_pkg::ORD_QTY_W){1'b0}}, ord_qty_reg};
        lvl_sat   = 1'b0;
        if (opp_stat.head_reach) begin
            // The order reaches the opposite best level: remove it whole.
            opp_op    = plom_pkg::OP_POP;
            act       = plom_pkg::ACT_CROSS;
            lvl_price = opp_stat.head_price;
            lvl_qty   = opp_stat.head_qty;
        end else if (own_stat.any_match) begin
            own_op  = plom_pkg::OP_ADD;
            act     = plom_pkg::ACT_ADD;
            lvl_qty = own_stat.add_qty;
            lvl_sat = own_stat.add_sat;
        end else if (own_stat.full) begin
            act     = plom_pkg::ACT_REJECT;
            lvl_qty = '0;
        end else begin
            own_op = plom_pkg::OP_INSERT;
        end
        if (!upd_fire) begin
            own_op = plom_pkg::OP_NONE;
            opp_op = plom_pkg::OP_NONE;
        end
    end

    always_comb begin
        bid_cmd.capture = s_accept;
        ask_cmd.capture = s_accept;
        bid_cmd.op      = ord_side_reg ? opp_op : own_op;
        ask_cmd.op      = ord_side_reg ? own_op : opp_op;
    end

    plom_book #(
        .LEVELS    (LEVELS),
        .DESCENDING(1'b1)
    ) u_bid_book (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (bid_cmd),
        .cmp_price(s_axis_tdata[31:0]),
        .ord_price(ord_price_reg),
        .ord_qty  (ord_qty_reg),
        .stat     (bid_stat)
    );

    plom_book #(
        .LEVELS    (LEVELS),
        .DESCENDING(1'b0)
    ) u_ask_book (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (ask_cmd),
        .cmp_price(s_axis_tdata[31:0]),
        .ord_price(ord_price_reg),
        .ord_qty  (ord_qty_reg),
        .stat     (ask_stat)
    );

    // Best prices after this order; an empty side reports price zero.
    always_comb begin
        m_data_next = {
            ask_stat.best_next_valid ? ask_stat.best_next_price : {plom_pkg::PRICE_W{1'b0}},
            ask_stat.best_next_valid,
            bid_stat.best_next_valid ? bid_stat.best_next_price : {plom_pkg::PRICE_W{1'b0}},
            bid_stat.best_next_valid,
            lvl_sat,
            lvl_qty,
            lvl_price
        };
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CMP: begin
                if (s_accept) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (upd_fire) begin
                    state_next = ST_CMP;
                end
            end
            default: begin
                state_next = ST_CMP;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (upd_fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CMP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ord_side_reg  <= s_axis_tuser;
            ord_price_reg <= s_axis_tdata[31:0];
            ord_qty_reg   <= s_axis_tdata[47:32];
        end
        if (upd_fire) begin
            m_action_reg <= act;
            m_data_reg   <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_action_reg;
    assign m_axis_tdata  = {5'b0, m_data_reg};

endmodule

FILE: tb/tb_price_level_order_matcher.sv
// Self-checking testbench for price_level_order_matcher: drives orders on the input stream
// and compares each result transaction with a predicted copy of both price level books.
// Depends on plom_pkg and the price_level_order_matcher RTL.
`timescale 1ns / 1ps

module tb_price_level_order_matcher;

    localparam int BOOK_LEVELS = 16;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Resting bids sit below MID_PRICE and resting asks above it, so that well-formed
    // traffic builds both books. Each side uses more prices than it has levels.
    localparam logic [plom_pkg::PRICE_W-1:0] MID_PRICE   = 32'h8000_0000;
    localparam int                           PRICE_SPAN  = 24;
    localparam logic [plom_pkg::PRICE_W-1:0] TOP_PRICE   = 32'hFFFF_FFFF;
    localparam int                           MAX_ERR_LOG = 100;

    // What one order is expected to report.
    typedef struct {
        plom_pkg::action_t            act;
        logic [plom_pkg::PRICE_W-1:0] lvl_price;
        logic [plom_pkg::QTY_W-1:0]   lvl_qty;
        logic                         sat;
        logic                         bid_valid;
        logic [plom_pkg::PRICE_W-1:0] bid_price;
        logic                         ask_valid;
        logic [plom_pkg::PRICE_W-1:0] ask_price;
    } level_report_t;

    // Shadow of both books plus the queue of reports still owed by the block.
    // Index 0 holds the bids (highest first), index 1 the asks (lowest first).
    class level_book_scoreboard;
        logic [plom_pkg::PRICE_W-1:0] lvl_price [2][BOOK_LEVELS];
        logic [plom_pkg::QTY_W-1:0]   lvl_qty   [2][BOOK_LEVELS];
        int                           depth     [2];
        level_report_t                expected_reports [$];
        int                           mismatches;
        int                           results_seen;

        function new();
            depth[0]     = 0;
            depth[1]     = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int owed();
            return expected_reports.size();
        endfunction

        function void report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_ERR_LOG)
                $display("%0t ns: mismatch at result %0d: %s", $time, results_seen, what);
        endfunction

        // Apply one accepted order to the shadow books and queue its report.
        function void note_order(logic side, logic [plom_pkg::PRICE_W-1:0] price,
                                 logic [plom_pkg::ORD_QTY_W-1:0] oqty);
            level_report_t                r;
            int                           own;
            int                           opp;
            int                           hit;
            int                           pos;
            int                           i;
            logic                         crosses;
            logic [plom_pkg::QTY_W:0]     sum;
            logic [plom_pkg::QTY_W-1:0]   oqty_wide;

            oqty_wide = {{(plom_pkg::QTY_W - plom_pkg::ORD_QTY_W){1'b0}}, oqty};
            own       = side;
            opp       = !side;
            r.act     = plom_pkg::ACT_NEW;
            r.lvl_price = price;
            r.lvl_qty = '0;
            r.sat     = 1'b0;
            crosses   = 1'b0;
            if (depth[opp] > 0)
                crosses = side ? (lvl_price[opp][0] >= price) : (lvl_price[opp][0] <= price);

            if (crosses) begin
                // The whole best opposite level goes; the order's quantity is dropped.
                r.act       = plom_pkg::ACT_CROSS;
                r.lvl_price = lvl_price[opp][0];
                r.lvl_qty   = lvl_qty[opp][0];
                for (i = 1; i < depth[opp]; i++) begin
                    lvl_price[opp][i-1] = lvl_price[opp][i];
                    lvl_qty[opp][i-1]   = lvl_qty[opp][i];
                end
                depth[opp]--;
            end else begin
                hit = -1;
                for (i = 0; i < depth[own]; i++)
                    if (lvl_price[own][i] == price)
                        hit = i;
                if (hit >= 0) begin
                    sum = {1'b0, lvl_qty[own][hit]} + {1'b0, oqty_wide};
                    if (sum[plom_pkg::QTY_W]) begin
                        sum   = {1'b0, {plom_pkg::QTY_W{1'b1}}};
                        r.sat = 1'b1;
                    end
                    lvl_qty[own][hit] = sum[plom_pkg::QTY_W-1:0];
                    r.act     = plom_pkg::ACT_ADD;
                    r.lvl_qty = sum[plom_pkg::QTY_W-1:0];
                end else if (depth[own] >= BOOK_LEVELS) begin
                    r.act = plom_pkg::ACT_REJECT;
                end else begin
                    pos = 0;
                    while (pos < depth[own] &&
                           (side ? (lvl_price[own][pos] < price) : (lvl_price[own][pos] > price)))
                        pos++;
                    for (i = depth[own]; i > pos; i--) begin
                        lvl_price[own][i] = lvl_price[own][i-1];
                        lvl_qty[own][i]   = lvl_qty[own][i-1];
                    end
                    lvl_price[own][pos] = price;
                    lvl_qty[own][pos]   = oqty_wide;
                    depth[own]++;
                    r.act     = plom_pkg::ACT_NEW;
                    r.lvl_qty = oqty_wide;
                end
            end

            r.bid_valid = depth[0] > 0;
            r.bid_price = (depth[0] > 0) ? lvl_price[0][0] : '0;
            r.ask_valid = depth[1] > 0;
            r.ask_price = (depth[1] > 0) ? lvl_price[1][0] : '0;
            expected_reports.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        endfunction

        function void check_result(logic [1:0] act, logic [135:0] data);
            level_report_t e;
            results_seen++;
            if (expected_reports.size() == 0) begin
                report_mismatch("result transaction with no order waiting");
                return;
            end
            e = expected_reports.pop_front();
            check_field("action",         32'(act),      32'(e.act));
            check_field("level_price",    data[31:0],    e.lvl_price);
            check_field("level_quantity", data[63:32],   e.lvl_qty);
            check_field("saturated",      32'(data[64]), 32'(e.sat));
            check_field("best_bid_valid", 32'(data[65]), 32'(e.bid_valid));
            check_field("best_bid_price", data[97:66],   e.bid_price);
            check_field("best_ask_valid", 32'(data[98]), 32'(e.ask_valid));
            check_field("best_ask_price", data[130:99],  e.ask_price);
        endfunction
    endclass

    logic         aclk;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata  = '0;   // order_price [31:0], order_quantity [47:32]
    logic         s_axis_tuser  = 1'b0; // order_side [0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;         // level_price, level_quantity, saturated,
                                        // best_bid_valid, best_bid_price,
                                        // best_ask_valid, best_ask_price
    logic [1:0]   m_axis_tuser;         // action [1:0]

    level_book_scoreboard scb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    price_level_order_matcher #(
        .LEVELS (BOOK_LEVELS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Result side: check every accepted transaction, then pick the next ready value.
    // A long hold-off requested by the stimulus takes priority over random stalls.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            scb.check_result(m_axis_tuser, m_axis_tdata);
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one order and return at the edge where it is accepted.
    task automatic send_order(logic side, logic [plom_pkg::PRICE_W-1:0] price,
                              logic [plom_pkg::ORD_QTY_W-1:0] oqty);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {oqty, price};
        s_axis_tuser  <= side;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        scb.note_order(side, price, oqty);
    endtask

    // Stop offering and wait until the block has returned every owed result.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (scb.owed() != 0);
    endtask

    task automatic send_random_order();
        int                             roll;
        int                             qroll;
        logic                           side;
        logic [plom_pkg::PRICE_W-1:0]   price;
        logic [plom_pkg::ORD_QTY_W-1:0] oqty;

        roll  = $urandom_range(99);
        qroll = $urandom_range(99);
        if (qroll < 10)
            oqty = '0;
        else if (qroll < 20)
            oqty = '1;
        else
            oqty = 16'($urandom_range(65535));

        if (roll < 40) begin
            side  = SIDE_BUY;
            price = MID_PRICE - 1 - $urandom_range(PRICE_SPAN - 1);
        end else if (roll < 80) begin
            side  = SIDE_SELL;
            price = MID_PRICE + 1 + $urandom_range(PRICE_SPAN - 1);
        end else if (roll < 88) begin
            // Aggressive buy: crosses whenever an ask from the regular sell traffic rests.
            side  = SIDE_BUY;
            price = ($urandom_range(1) != 0) ? TOP_PRICE : MID_PRICE + PRICE_SPAN + 1;
        end else if (roll < 96) begin
            side  = SIDE_SELL;
            price = ($urandom_range(1) != 0) ? '0 : MID_PRICE - PRICE_SPAN - 1;
        end else begin
            // Noise: any side at any price.
            side  = 1'($urandom_range(1));
            price = $urandom;
        end
        send_order(side, price, oqty);
    endtask

    // Extremes, both kinds of cross, zero quantity, empty sides and a full bid book.
    task automatic run_directed_orders();
        int i;
        send_order(SIDE_SELL, 32'd100, 16'd5);      // new ask, bid side empty
        send_order(SIDE_BUY,  32'd100, 16'd7);      // buy at the ask price crosses it
        send_order(SIDE_BUY,  32'd0,   16'd0);      // zero quantity still rests
        send_order(SIDE_BUY,  32'd0,   16'hFFFF);   // add to existing level
        send_order(SIDE_SELL, TOP_PRICE, 16'hFFFF); // ask at the top price
        send_order(SIDE_SELL, 32'd0,   16'd1);      // sell at the bid price crosses it
        send_order(SIDE_BUY,  TOP_PRICE, 16'd3);    // removes the top ask
        for (i = 0; i < BOOK_LEVELS; i++)
            send_order(SIDE_BUY, 32'd1000 + 32'(((i * 7) % BOOK_LEVELS) * 10), 16'(i));
        send_order(SIDE_BUY, 32'd1005, 16'd9);      // new level on a full book
        send_order(SIDE_BUY, 32'd1000, 16'd4);      // adding to a full book is fine
    endtask

    initial begin
        int i;
        scb = new();
        send_idle_pct = 38;
        recv_idle_pct = 82;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed_orders();
        wait_for_results();

        for (i = 0; i < 200; i++) begin
            // Long receiver stall while orders keep coming: the block must back up.
            if (i == 100)
                hold_left = 80;
            send_random_order();
        end
        wait_for_results();

        send_idle_pct = 82;
        recv_idle_pct = 38;
        for (i = 0; i < 200; i++)
            send_random_order();
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (i = 0; i < 125; i++)
            send_random_order();
        wait_for_results();
        repeat (8) @(posedge aclk);

        if (scb.mismatches == 0 && scb.owed() == 0)
            $display("tb_price_level_order_matcher: PASS");
        else
            $display("tb_price_level_order_matcher: FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #8000000;
        $display("tb_price_level_order_matcher: FAIL");
        $finish;
    end

endmodule
